FILE: src/drt_pkg.sv
`default_nettype none
package drt_pkg;

  localparam int MAX_RECTS_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int ACTION_W       = 2;
  localparam int STATUS_W       = 3;
  localparam int COUNT_OUT_W    = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_CHECK = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_RSVD  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_OVERLAP  = 3'd1,
    ST_DEGEN    = 3'd2,
    ST_FULL     = 3'd3,
    ST_CHECKED  = 3'd4,
    ST_CLEARED  = 3'd5,
    ST_RSVD6    = 3'd6,
    ST_RSVD7    = 3'd7
  } status_e;

endpackage
`default_nettype wire

FILE: src/drt_if.sv
`default_nettype none
interface drt_in_if
  import drt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [FIELD_W-1:0]  rect_x;
  logic [FIELD_W-1:0]  rect_y;
  logic [FIELD_W-1:0]  rect_width;
  logic [FIELD_W-1:0]  rect_height;

  modport source (output valid, action, rect_x, rect_y, rect_width, rect_height,
                  input ready);
  modport sink   (input valid, action, rect_x, rect_y, rect_width, rect_height,
                  output ready);
endinterface

interface drt_out_if
  import drt_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   is_disjoint;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, is_disjoint, status, entry_count, input ready);
  modport sink   (input valid, is_disjoint, status, entry_count, output ready);
endinterface
`default_nettype wire

FILE: src/drt_cell.sv
`default_nettype none
module drt_cell
  import drt_pkg::*;
#(
  parameter int CW    = COORD_BITS_DEF,
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire logic [CW-1:0]    sh_x_i,
  input  wire logic [CW-1:0]    sh_y_i,
  input  wire logic [CW-1:0]    sh_w_i,
  input  wire logic [CW-1:0]    sh_h_i,
  input  wire logic [CW-1:0]    qx_i,
  input  wire logic [CW-1:0]    qy_i,
  input  wire logic [CW-1:0]    qw_i,
  input  wire logic [CW-1:0]    qh_i,
  input  wire logic [CNT_W-1:0] count_i,
  output logic      [CW-1:0]    x_o,
  output logic      [CW-1:0]    y_o,
  output logic      [CW-1:0]    w_o,
  output logic      [CW-1:0]    h_o,
  output logic                  hit_o
);

  logic [CW-1:0] x_q, y_q, w_q, h_q;
  logic [CW:0]   s_right, s_bot, q_right, q_bot;
  logic          apart;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      x_q <= sh_x_i;
      y_q <= sh_y_i;
      w_q <= sh_w_i;
      h_q <= sh_h_i;
    end
  end

  always_comb begin
    s_right = {1'b0, x_q} + {1'b0, w_q};
    s_bot   = {1'b0, y_q} + {1'b0, h_q};
    q_right = {1'b0, qx_i} + {1'b0, qw_i};
    q_bot   = {1'b0, qy_i} + {1'b0, qh_i};
    apart   = (s_right <= {1'b0, qx_i}) || (q_right <= {1'b0, x_q}) ||
              (s_bot   <= {1'b0, qy_i}) || (q_bot   <= {1'b0, y_q});
    hit_o   = (count_i > CNT_W'(IDX)) && !apart;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign w_o = w_q;
  assign h_o = h_q;

endmodule
`default_nettype wire

FILE: src/disjoint_rect_table_core.sv
// An accepted input is registered as the query; in S_EVAL the compare against
// every stored entry happens across the cell row and the result is registered;
// a stalled output holds it in S_EVAL, and no new input is taken until S_IDLE.
// Reset: asynchronous, active low; clears the entry count and control state.
// Stored rectangles are not cleared; only cells below the count take part.
`default_nettype none
module disjoint_rect_table_core
  import drt_pkg::*;
#(
  parameter int MAX_RECTS  = MAX_RECTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  drt_in_if.sink     in_i,
  drt_out_if.source  out_o
);

  localparam int CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);

  typedef enum logic {S_IDLE, S_EVAL} state_e;

  typedef struct packed {
    logic                is_disjoint;
    logic [STATUS_W-1:0] status;
    logic                shift;
    logic [CNT_W-1:0]    count;
  } decision_t;

  state_e              state_q;
  action_e             act_q;
  logic [CW-1:0]       qx_q, qy_q, qw_q, qh_q;
  logic [CNT_W-1:0]    count_q;
  logic                out_valid_q;
  logic                disj_q;
  logic [STATUS_W-1:0] status_q;

  logic [CW-1:0]        cx [MAX_RECTS+1];
  logic [CW-1:0]        cy [MAX_RECTS+1];
  logic [CW-1:0]        cwd[MAX_RECTS+1];
  logic [CW-1:0]        cht[MAX_RECTS+1];
  logic [MAX_RECTS-1:0] hits;
  logic                 eval_go;
  logic                 degen;
  logic                 overlap;
  decision_t            dec;

  assign cx[0]  = qx_q;
  assign cy[0]  = qy_q;
  assign cwd[0] = qw_q;
  assign cht[0] = qh_q;

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    drt_cell #(.CW(CW), .CNT_W(CNT_W), .IDX(i)) u_cell (
      .clk_i   (clk_i),
      .shift_i (dec.shift),
      .sh_x_i  (cx[i]),
      .sh_y_i  (cy[i]),
      .sh_w_i  (cwd[i]),
      .sh_h_i  (cht[i]),
      .qx_i    (qx_q),
      .qy_i    (qy_q),
      .qw_i    (qw_q),
      .qh_i    (qh_q),
      .count_i (count_q),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .w_o     (cwd[i+1]),
      .h_o     (cht[i+1]),
      .hit_o   (hits[i])
    );
  end

  assign eval_go = (state_q == S_EVAL) && (!out_valid_q || out_o.ready);
  assign degen   = (qw_q == '0) || (qh_q == '0);
  assign overlap = |hits;

  always_comb begin
    dec = '{is_disjoint: 1'b0, status: ST_CHECKED, shift: 1'b0, count: count_q};
    unique case (act_q)
      ACT_CLEAR: begin
        dec.status = ST_CLEARED;
        dec.count  = '0;
      end
      ACT_ADD: begin
        if (degen) begin
          dec.is_disjoint = 1'b1;
          dec.status      = ST_DEGEN;
        end else if (overlap) begin
          dec.status = ST_OVERLAP;
        end else if (count_q >= CNT_W'(MAX_RECTS)) begin
          dec.is_disjoint = 1'b1;
          dec.status      = ST_FULL;
        end else begin
          dec.is_disjoint = 1'b1;
          dec.status      = ST_STORED;
          dec.shift       = eval_go;
          dec.count       = count_q + CNT_W'(1);
        end
      end
      default: begin
        dec.is_disjoint = degen || !overlap;
        dec.status      = ST_CHECKED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      act_q       <= ACT_CHECK;
    end else begin
      if (out_valid_q && out_o.ready && !eval_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            act_q   <= action_e'(in_i.action);
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (eval_go) begin
            count_q     <= dec.count;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // query and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      qx_q <= in_i.rect_x[CW-1:0];
      qy_q <= in_i.rect_y[CW-1:0];
      qw_q <= in_i.rect_width[CW-1:0];
      qh_q <= in_i.rect_height[CW-1:0];
    end
    if (eval_go) begin
      disj_q   <= dec.is_disjoint;
      status_q <= dec.status;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.is_disjoint = disj_q;
  assign out_o.status      = status_q;
  assign out_o.entry_count = COUNT_OUT_W'(count_q);

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECTS))
    else $error("entry count above table depth");

  a_shift_inc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec.shift |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("store without count increment");

  a_clear_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_CLEARED) |-> (count_q == '0))
    else $error("clear result with nonzero count");

  a_eval_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && out_valid_q && !out_o.ready) |=> (state_q == S_EVAL))
    else $error("result produced while output slot busy");

endmodule
`default_nettype wire
